>>> hw/rtl/na_aware_integer_alu_unit_macros.svh
// Assertion helpers for the NA-aware integer ALU
`ifndef NA_AWARE_INTEGER_ALU_UNIT_MACROS_SVH
`define NA_AWARE_INTEGER_ALU_UNIT_MACROS_SVH

// Clocked check, disabled while reset is high
`define NAAI_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define NAAI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/naai_pkg.sv
package naai_pkg;

   localparam logic [2:0] MODE_ADD = 3'd0;
   localparam logic [2:0] MODE_SUB = 3'd1;
   localparam logic [2:0] MODE_MUL = 3'd2;
   localparam logic [2:0] MODE_MOD = 3'd3;
   localparam logic [2:0] MODE_DIV = 3'd4;

   localparam logic [31:0] NA_MARK = 32'h8000_0000;
   // magnitude width of a non-missing operand; one divider cell per bit
   localparam int DIV_W = 31;
   localparam int LATENCY = 2 + DIV_W + 1;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [31:0] lhs;
      logic signed [31:0] rhs;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result;
      logic               is_missing;
      logic               overflowed;
   } rsp_type;

   // item context traveling along the divider chain
   typedef struct packed {
      logic               valid;
      logic               use_div;
      logic               is_mod;
      logic               lhs_neg;
      logic signed [31:0] rhs;
      logic [DIV_W-1:0]   dvsr;
      rsp_type            pre;
   } side_type;

endpackage

>>> hw/rtl/na_aware_integer_alu_unit.sv
// Every mode takes the same path from the start transfer to the result transfer.
// Throughput: one operation per cycle; busy stays low, start may be held high.
// Two input stages (multiplier, range check), 31 restoring divider cells, one output stage.
// Synchronous active-high reset clears all valid flags; payload registers are not reset.
// Results are strobed for one cycle; the receiver cannot stall.
`include "na_aware_integer_alu_unit_macros.svh"

module na_aware_integer_alu_unit import naai_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   side_type         side_c [DIV_W+1];
   logic [DIV_W-1:0] rem_c  [DIV_W+1];
   logic [DIV_W-1:0] num_c  [DIV_W+1];
   logic             accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   naai_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_item (req_item),
      .side_out (side_c[0]),
      .rem_out  (rem_c[0]),
      .num_out  (num_c[0])
   );

   for (genvar i = 0; i < DIV_W; i++) begin : g_cell
      naai_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .side_in  (side_c[i]),
         .rem_in   (rem_c[i]),
         .num_in   (num_c[i]),
         .side_out (side_c[i+1]),
         .rem_out  (rem_c[i+1]),
         .num_out  (num_c[i+1])
      );
   end

   naai_back u_back (
      .clock     (clock),
      .reset     (reset),
      .side_in   (side_c[DIV_W]),
      .rem_in    (rem_c[DIV_W]),
      .quo_in    (num_c[DIV_W]),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   `NAAI_ASSERT(a_latency, clock, reset, accept |-> ##(LATENCY) rsp_valid, "result strobe missing")
   `NAAI_ASSERT(a_ovf_missing, clock, reset, (rsp_valid && rsp_item.overflowed) |-> (rsp_item.is_missing && rsp_item.result == NA_MARK), "overflow without mark")
   `NAAI_ASSERT(a_missing_mark, clock, reset, (rsp_valid && rsp_item.is_missing) |-> (rsp_item.result == NA_MARK), "missing flag without mark")
   `NAAI_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "strobe right after reset")

endmodule

>>> hw/rtl/naai_front.sv
module naai_front import naai_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  req_type          req_item,
   output side_type         side_out,
   output logic [DIV_W-1:0] rem_out,
   output logic [DIV_W-1:0] num_out
);

   logic               v1_ff, v1_in;
   req_type            r1_ff;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [32:0] sum_ff, diff_ff;
   side_type           side_ff, side_in;
   logic [DIV_W-1:0]   num_ff, num_in;

   assign v1_in   = accept;
   assign prod_in = req_item.lhs * req_item.rhs;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= v1_in;
      r1_ff   <= req_item;
      prod_ff <= prod_in;
      sum_ff  <= 33'(req_item.lhs) + 33'(req_item.rhs);
      diff_ff <= 33'(req_item.lhs) - 33'(req_item.rhs);
   end

   logic               miss;
   logic signed [63:0] t;
   logic               fits;
   logic [31:0]        abs_l, abs_r;

   always_comb begin
      miss  = (r1_ff.lhs == NA_MARK) || (r1_ff.rhs == NA_MARK);
      abs_l = r1_ff.lhs[31] ? 32'(-r1_ff.lhs) : r1_ff.lhs;
      abs_r = r1_ff.rhs[31] ? 32'(-r1_ff.rhs) : r1_ff.rhs;
      unique case (r1_ff.mode)
         MODE_ADD: t = 64'(sum_ff);
         MODE_SUB: t = 64'(diff_ff);
         default:  t = prod_ff;
      endcase
      // fits in 32 bits and is not the mark
      fits = (t[63:31] == '0) || ((t[63:31] == '1) && (t[30:0] != '0));

      side_in         = '0;
      side_in.valid   = v1_ff;
      side_in.lhs_neg = r1_ff.lhs[31];
      side_in.rhs     = r1_ff.rhs;
      side_in.dvsr    = abs_r[DIV_W-1:0];
      side_in.is_mod  = (r1_ff.mode == MODE_MOD);
      if (r1_ff.mode > MODE_DIV) begin
         side_in.pre = '0;
      end else if (miss) begin
         side_in.pre.result     = NA_MARK;
         side_in.pre.is_missing = 1'b1;
      end else if (r1_ff.mode <= MODE_MUL) begin
         if (fits) begin
            side_in.pre.result = t[31:0];
         end else begin
            side_in.pre.result     = NA_MARK;
            side_in.pre.is_missing = 1'b1;
            side_in.pre.overflowed = 1'b1;
         end
      end else if (r1_ff.rhs == '0) begin
         // modulo by zero is missing, division by zero is zero
         side_in.pre.result     = side_in.is_mod ? NA_MARK : '0;
         side_in.pre.is_missing = side_in.is_mod;
      end else begin
         side_in.use_div = 1'b1;
      end
      num_in = abs_l[DIV_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) side_ff.valid <= 1'b0;
      else       side_ff.valid <= side_in.valid;
      side_ff.use_div <= side_in.use_div;
      side_ff.is_mod  <= side_in.is_mod;
      side_ff.lhs_neg <= side_in.lhs_neg;
      side_ff.rhs     <= side_in.rhs;
      side_ff.dvsr    <= side_in.dvsr;
      side_ff.pre     <= side_in.pre;
      num_ff          <= num_in;
   end

   assign side_out = side_ff;
   assign rem_out  = '0;
   assign num_out  = num_ff;

endmodule

>>> hw/rtl/naai_div_cell.sv
module naai_div_cell import naai_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  side_type         side_in,
   input  logic [DIV_W-1:0] rem_in,
   input  logic [DIV_W-1:0] num_in,
   output side_type         side_out,
   output logic [DIV_W-1:0] rem_out,
   output logic [DIV_W-1:0] num_out
);

   side_type         side_ff;
   logic [DIV_W-1:0] rem_ff, rem_nx;
   logic [DIV_W-1:0] num_ff, num_nx;
   logic [DIV_W:0]   shifted;
   logic             ge;

   // one restoring step: quotient bit shifts into num as dividend bit leaves
   always_comb begin
      shifted = {rem_in, num_in[DIV_W-1]};
      ge      = shifted >= {1'b0, side_in.dvsr};
      rem_nx  = ge ? DIV_W'(shifted - {1'b0, side_in.dvsr}) : shifted[DIV_W-1:0];
      num_nx  = {num_in[DIV_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) side_ff.valid <= 1'b0;
      else       side_ff.valid <= side_in.valid;
      side_ff.use_div <= side_in.use_div;
      side_ff.is_mod  <= side_in.is_mod;
      side_ff.lhs_neg <= side_in.lhs_neg;
      side_ff.rhs     <= side_in.rhs;
      side_ff.dvsr    <= side_in.dvsr;
      side_ff.pre     <= side_in.pre;
      rem_ff          <= rem_nx;
      num_ff          <= num_nx;
   end

   assign side_out = side_ff;
   assign rem_out  = rem_ff;
   assign num_out  = num_ff;

endmodule

>>> hw/rtl/naai_back.sv
module naai_back import naai_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  side_type         side_in,
   input  logic [DIV_W-1:0] rem_in,
   input  logic [DIV_W-1:0] quo_in,
   output logic             rsp_valid,
   output rsp_type          rsp_item
);

   logic               valid_ff;
   rsp_type            rsp_ff, rsp_in;
   logic               neg_q;
   logic signed [31:0] tq, tr;

   always_comb begin
      neg_q = side_in.lhs_neg ^ side_in.rhs[31];
      tq    = neg_q ? 32'(-{1'b0, quo_in}) : {1'b0, quo_in};
      tr    = side_in.lhs_neg ? 32'(-{1'b0, rem_in}) : {1'b0, rem_in};
      rsp_in = side_in.pre;
      if (side_in.use_div) begin
         // floor correction when remainder and divisor differ in sign
         if ((rem_in != '0) && neg_q) begin
            tq = tq - 32'sd1;
            tr = tr + side_in.rhs;
         end
         rsp_in.result     = side_in.is_mod ? tr : tq;
         rsp_in.is_missing = 1'b0;
         rsp_in.overflowed = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= side_in.valid;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
